// ===== src/hbkd_pkg.sv =====
// Package for the HID boot keyboard report differ.
// Holds the transaction types, kind codes and report constants.
// No dependencies.
`timescale 1ns / 1ps

package hbkd_pkg;

    localparam int BYTE_W      = 8;
    localparam int INPUT_SLOTS = 6;

    // Item kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Reports shorter than this are dropped.
    localparam logic [6:0] MIN_REPORT_BYTES = 7'd8;

    typedef struct packed {
        logic              kind;
        logic [6:0]        report_bytes;
        logic [BYTE_W-1:0] modifiers;
        logic [BYTE_W-1:0] key_slot_0;
        logic [BYTE_W-1:0] key_slot_1;
        logic [BYTE_W-1:0] key_slot_2;
        logic [BYTE_W-1:0] key_slot_3;
        logic [BYTE_W-1:0] key_slot_4;
        logic [BYTE_W-1:0] key_slot_5;
    } t_in;

    typedef struct packed {
        logic              is_modifier;
        logic [BYTE_W-1:0] event_code;
        logic              released;
        logic              last;
    } t_out;

    // Key slot by index; slots past the report's six read as empty.
    function automatic logic [BYTE_W-1:0] slot_of(t_in item, int idx);
        logic [BYTE_W-1:0] v;
        case (idx)
            0:       v = item.key_slot_0;
            1:       v = item.key_slot_1;
            2:       v = item.key_slot_2;
            3:       v = item.key_slot_3;
            4:       v = item.key_slot_4;
            5:       v = item.key_slot_5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/hid_boot_keyboard_report_diff.sv =====
// Top level of the HID boot keyboard report differ.
// Depends on hbkd_pkg, hbkd_diff and hbkd_emit.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   i_in_data   (hbkd_pkg::t_in)
//  out       output     o_out_valid / i_out_ready o_out_data  (hbkd_pkg::t_out)
//
// A transaction on the input channel lands in the input register. From there it is
// compared against the held report and its events move into the event register,
// which hands them to the output register one per cycle while the output is not
// stalled; a report with no events leaves the event register free.
// The first event reaches the output through the input, event and output registers.
// Reset (synchronous, active low) clears the held report and all valid flags.
// A stall on the output holds the events in place; the input register keeps taking
// transactions as long as the event register frees up behind it.

module hid_boot_keyboard_report_diff #(
    parameter int KEY_SLOTS     = 6,
    parameter int MODIFIER_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hbkd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hbkd_pkg::t_out o_out_data
);

    localparam int NE = MODIFIER_BITS + 2 * KEY_SLOTS;

    // Input register.
    logic          r_in_vld;
    hbkd_pkg::t_in r_in;

    logic                        w_ev_free;
    logic                        w_take;
    logic                        w_in_ready;
    logic [NE-1:0]               w_ev_mask;
    logic [hbkd_pkg::BYTE_W-1:0] w_ev_code [NE];
    logic [NE-1:0]               w_ev_rel;

    // The held report is updated at the moment an item leaves the input register,
    // so items are judged strictly in arrival order.
    assign w_take     = r_in_vld && w_ev_free;
    assign w_in_ready = !r_in_vld || w_take;
    assign o_in_ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_ready) begin
            r_in <= i_in_data;
        end
    end

    hbkd_diff #(
        .KEY_SLOTS    (KEY_SLOTS),
        .MODIFIER_BITS(MODIFIER_BITS)
    ) u_diff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_in),
        .i_take   (w_take),
        .o_ev_mask(w_ev_mask),
        .o_ev_code(w_ev_code),
        .o_ev_rel (w_ev_rel)
    );

    hbkd_emit #(
        .KEY_SLOTS    (KEY_SLOTS),
        .MODIFIER_BITS(MODIFIER_BITS)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take),
        .i_ev_mask  (w_ev_mask),
        .i_ev_code  (w_ev_code),
        .i_ev_rel   (w_ev_rel),
        .o_free     (w_ev_free),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

// ===== src/hbkd_diff.sv =====
// Held report state and the compare logic that builds the event set of one report.
// Depends on hbkd_pkg.
`timescale 1ns / 1ps

module hbkd_diff #(
    parameter int KEY_SLOTS     = 6,
    parameter int MODIFIER_BITS = 8,
    localparam int NE           = MODIFIER_BITS + 2 * KEY_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hbkd_pkg::t_in              i_item,
    input  logic                       i_take,
    output logic [NE-1:0]              o_ev_mask,
    output logic [hbkd_pkg::BYTE_W-1:0] o_ev_code [NE],
    output logic [NE-1:0]              o_ev_rel
);

    logic [hbkd_pkg::BYTE_W-1:0] r_held_mods;
    logic [hbkd_pkg::BYTE_W-1:0] r_held_keys [KEY_SLOTS];
    logic [hbkd_pkg::BYTE_W-1:0] w_now [KEY_SLOTS];
    logic [KEY_SLOTS-1:0]        w_still;
    logic [KEY_SLOTS-1:0]        w_was;
    logic                        w_report_ok;

    assign w_report_ok = (i_item.kind == hbkd_pkg::KIND_REPORT) &&
                         (i_item.report_bytes >= hbkd_pkg::MIN_REPORT_BYTES);

    always_comb begin
        for (int j = 0; j < KEY_SLOTS; j++) begin
            w_now[j] = hbkd_pkg::slot_of(i_item, j);
        end
    end

    // Cross compare of old and new slots; each pair is independent.
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            w_still[i] = 1'b0;
            w_was[i]   = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                w_still[i] = w_still[i] | (w_now[j] == r_held_keys[i]);
                w_was[i]   = w_was[i] | (r_held_keys[j] == w_now[i]);
            end
        end
    end

    // Event order: modifier bits, then releases by old slot, then presses by new slot.
    always_comb begin
        for (int b = 0; b < MODIFIER_BITS; b++) begin
            o_ev_mask[b] = w_report_ok && (i_item.modifiers[b] ^ r_held_mods[b]);
            o_ev_code[b] = hbkd_pkg::BYTE_W'(b);
            o_ev_rel[b]  = ~i_item.modifiers[b];
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            o_ev_mask[MODIFIER_BITS + i] = w_report_ok && (r_held_keys[i] != '0) && !w_still[i];
            o_ev_code[MODIFIER_BITS + i] = r_held_keys[i];
            o_ev_rel[MODIFIER_BITS + i]  = 1'b1;
        end
        for (int j = 0; j < KEY_SLOTS; j++) begin
            o_ev_mask[MODIFIER_BITS + KEY_SLOTS + j] = w_report_ok && (w_now[j] != '0) &&
                                                       !w_was[j];
            o_ev_code[MODIFIER_BITS + KEY_SLOTS + j] = w_now[j];
            o_ev_rel[MODIFIER_BITS + KEY_SLOTS + j]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_mods <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_held_keys[i] <= '0;
            end
        end else if (i_take) begin
            if (i_item.kind == hbkd_pkg::KIND_CLEAR) begin
                r_held_mods <= '0;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    r_held_keys[i] <= '0;
                end
            end else if (w_report_ok) begin
                r_held_mods <= i_item.modifiers;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    r_held_keys[i] <= w_now[i];
                end
            end
        end
    end

endmodule

// ===== src/hbkd_emit.sv =====
// Event register and output register: hands out the pending events of one report in order.
// Depends on hbkd_pkg.
`timescale 1ns / 1ps

module hbkd_emit #(
    parameter int KEY_SLOTS     = 6,
    parameter int MODIFIER_BITS = 8,
    localparam int NE           = MODIFIER_BITS + 2 * KEY_SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [NE-1:0]               i_ev_mask,
    input  logic [hbkd_pkg::BYTE_W-1:0] i_ev_code [NE],
    input  logic [NE-1:0]               i_ev_rel,
    output logic                        o_free,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output hbkd_pkg::t_out              o_out_data
);

    logic [NE-1:0]               r_ev_mask;
    logic [hbkd_pkg::BYTE_W-1:0] r_ev_code [NE];
    logic [NE-1:0]               r_ev_rel;
    logic                        r_out_vld;
    hbkd_pkg::t_out              r_out;

    logic [NE-1:0]               w_pick;
    logic [NE-1:0]               w_rest;
    logic                        w_out_free;
    logic                        w_fire;
    logic [hbkd_pkg::BYTE_W-1:0] w_code;
    logic                        w_rel;

    // Lowest pending event, isolated as a one-hot vector.
    assign w_pick     = r_ev_mask & (~r_ev_mask + NE'(1));
    assign w_rest     = r_ev_mask & ~w_pick;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_fire     = (r_ev_mask != '0) && w_out_free;
    assign o_free     = (r_ev_mask == '0) || (w_fire && (w_rest == '0));

    always_comb begin
        w_code = '0;
        w_rel  = 1'b0;
        for (int i = 0; i < NE; i++) begin
            if (w_pick[i]) begin
                w_code = w_code | r_ev_code[i];
                w_rel  = w_rel | r_ev_rel[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_mask <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_ev_mask <= i_ev_mask;
            end else if (w_fire) begin
                r_ev_mask <= w_rest;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev_code <= i_ev_code;
            r_ev_rel  <= i_ev_rel;
        end
        if (w_fire) begin
            r_out.is_modifier <= |w_pick[MODIFIER_BITS-1:0];
            r_out.event_code  <= w_code;
            r_out.released    <= w_rel;
            r_out.last        <= (w_rest == '0);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_pick))
        else $error("event pick is not one-hot");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_ev_mask == '0) || (w_fire && (w_rest == '0)))
        else $error("new report loaded over pending events");

    a_pending_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev_mask != '0) && !r_out_vld |=> r_out_vld)
        else $error("pending event not moved to the free output register");

    a_last_ends_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_rest == '0) && !i_load |=> (r_ev_mask == '0) && r_out.last)
        else $error("final event of a report not flagged");

endmodule
